/* src/icdf_pkg.sv */
// ----------------------------------------------------------------------------
// icdf_pkg - shared definitions for the inverse-CDF table sampler
// Operation and status codes, the sequencer states and the shared unit's
// operation select.
// ----------------------------------------------------------------------------
package icdf_pkg;

  // Command codes carried on in_op
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // Shared add/subtract unit operation
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  // Sample sequencer
  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_SEARCH_RD,
    S_SEARCH_CMP,
    S_UP_RD,
    S_LO_RD,
    S_WIDTH,
    S_OFFSET,
    S_DIV_FRAC,
    S_DIV_PROB
  } state_t;

endpackage

/* src/icdf_alu.sv */
// ----------------------------------------------------------------------------
// icdf_alu - shared add/subtract unit
// One adder shared by the append sum and the sampler's main arithmetic:
// multiply accumulate, search compare, bin width, offset and division trial
// subtraction. A set MSB after subtraction flags a borrow.
// ----------------------------------------------------------------------------
module icdf_alu #(
  parameter int unsigned W = 26
) (
  input  icdf_pkg::alu_op_t op,
  input  logic [W-1:0]      a,
  input  logic [W-1:0]      b,
  output logic [W-1:0]      res
);

  // two's complement add or subtract
  always_comb begin
    unique case (op)
      icdf_pkg::ALU_ADD: res = a + b;
      icdf_pkg::ALU_SUB: res = a - b;
      default:           res = a + b;
    endcase
  end

endmodule

/* src/icdf_table.sv */
// ----------------------------------------------------------------------------
// icdf_table - prefix-sum table storage
// Single write port, single read port with registered read data.
// Entries are undefined until written.
// ----------------------------------------------------------------------------
module icdf_table #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned DATA_W = 24
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* src/inverse_cdf_table_sampler.sv */
// ----------------------------------------------------------------------------
// inverse_cdf_table_sampler - inverse-CDF sampler over a table of weights
// Keeps weights as running prefix sums and draws bins from the resulting
// piecewise-constant distribution.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Clear, append and
// any sample that meets an empty table or a zero total complete without
// the sequencer: the result strobes on out_valid at the next cycle. A real
// sample runs through the single shared adder: a shift-add multiply over the
// FRACTION_BITS low bits of the uniform for the target, binary-search probes
// of a registered table read then a compare (up to ceil(log2(entries))
// probes) plus one more read once the search has closed, S_UP_RD, S_LO_RD,
// S_WIDTH and S_OFFSET to fetch the bin bounds and form width and offset,
// then a restoring division of FRACTION_BITS quotient bits for the offset
// and, unless the bin holds the whole weight, another for the probability.
// busy falls as the result strobes, so a new command can be taken while the
// result is shown, but never before the last sample is through.
// Each result is shown on out_valid for one cycle only; the receiver cannot
// stall, so it must take every beat as it appears.
// ----------------------------------------------------------------------------
module inverse_cdf_table_sampler #(
  parameter int unsigned TABLE_DEPTH   = 256,
  parameter int unsigned WEIGHT_BITS   = 16,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_weight,
  input  logic [15:0] in_uniform,
  output logic        out_valid,
  output logic [7:0]  out_bin_index,
  output logic [15:0] out_bin_fraction,
  output logic [15:0] out_probability,
  output logic [1:0]  out_status
);

  localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SUM_W  = WEIGHT_BITS + IDX_W;
  localparam int unsigned ALU_W  = SUM_W + 2;
  localparam int unsigned STEP_W = $clog2(FRACTION_BITS);

  // control state
  icdf_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [SUM_W-1:0] total_r, total_nxt;
  logic             out_valid_r, out_valid_nxt;

  // datapath registers
  logic [SUM_W-1:0]         acc_r, acc_nxt;
  logic [FRACTION_BITS-1:0] sh_r, sh_nxt;
  logic [SUM_W-1:0]         rem_r, rem_nxt;
  logic [SUM_W-1:0]         w_r, w_nxt;
  logic [SUM_W-1:0]         low_r, low_nxt;
  logic [SUM_W-1:0]         up_r, up_nxt;
  logic [FRACTION_BITS-1:0] frac_r, frac_nxt;
  logic [IDX_W-1:0]         lo_r, lo_nxt;
  logic [IDX_W-1:0]         hi_r, hi_nxt;
  logic [IDX_W-1:0]         mid_r, mid_nxt;
  logic [STEP_W-1:0]        step_r, step_nxt;
  logic [7:0]               bin_r, bin_nxt;
  logic [15:0]              bfrac_r, bfrac_nxt;
  logic [15:0]              prob_r, prob_nxt;
  logic [1:0]               status_r, status_nxt;

  // shared unit and table connections
  icdf_pkg::alu_op_t alu_op;
  logic [ALU_W-1:0]  alu_a, alu_b, alu_res;
  logic              borrow;
  logic              tbl_wr_en;
  logic [IDX_W-1:0]  tbl_rd_addr;
  logic [SUM_W-1:0]  tbl_rd_data;

  // helper wires
  logic                     accept;
  logic                     table_full;
  logic [31:0]              weight_ext, uniform_ext;
  logic [WEIGHT_BITS-1:0]   w_eff;
  logic [FRACTION_BITS-1:0] u_eff;
  logic [IDX_W:0]           mid_sum;
  logic [IDX_W-1:0]         mid_c;
  logic [CNT_W-1:0]         last_entry;
  logic [SUM_W-1:0]         lower_c;
  logic [FRACTION_BITS-1:0] quot_nxt;
  logic [SUM_W-1:0]         div_rem;
  logic [31:0]              lo_ext, frac_ext, quot_ext;
  logic                     step_last;

  assign accept      = start && (state_r == icdf_pkg::S_IDLE);
  assign table_full  = (count_r == CNT_W'(TABLE_DEPTH));
  assign weight_ext  = 32'(in_weight);
  assign uniform_ext = 32'(in_uniform);
  assign w_eff       = weight_ext[WEIGHT_BITS-1:0];
  assign u_eff       = uniform_ext[FRACTION_BITS-1:0];
  assign mid_sum     = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_c       = mid_sum[IDX_W:1];
  assign last_entry  = count_r - CNT_W'(1);
  assign lower_c     = (lo_r == '0) ? '0 : tbl_rd_data;
  assign borrow      = alu_res[ALU_W-1];
  assign step_last   = (step_r == '0);
  assign lo_ext      = 32'(lo_r);
  assign frac_ext    = 32'(frac_r);
  assign quot_ext    = 32'(quot_nxt);

  // division step: keep the trial difference unless it borrowed
  assign quot_nxt = {sh_r[FRACTION_BITS-2:0], ~borrow};
  assign div_rem  = borrow ? {rem_r[SUM_W-2:0], 1'b0} : alu_res[SUM_W-1:0];

  // shared unit operand select
  always_comb begin
    alu_op = icdf_pkg::ALU_ADD;
    alu_a  = ALU_W'(total_r);
    alu_b  = ALU_W'(w_eff);
    unique case (state_r)
      icdf_pkg::S_MUL: begin
        alu_a = ALU_W'(acc_r);
        alu_b = sh_r[0] ? ALU_W'(total_r) : '0;
      end
      icdf_pkg::S_SEARCH_CMP: begin
        alu_op = icdf_pkg::ALU_SUB;
        alu_a  = ALU_W'(acc_r);
        alu_b  = ALU_W'(tbl_rd_data);
      end
      icdf_pkg::S_WIDTH: begin
        alu_op = icdf_pkg::ALU_SUB;
        alu_a  = ALU_W'(up_r);
        alu_b  = ALU_W'(lower_c);
      end
      icdf_pkg::S_OFFSET: begin
        alu_op = icdf_pkg::ALU_SUB;
        alu_a  = ALU_W'(acc_r);
        alu_b  = ALU_W'(low_r);
      end
      icdf_pkg::S_DIV_FRAC: begin
        alu_op = icdf_pkg::ALU_SUB;
        alu_a  = {1'b0, rem_r, 1'b0};
        alu_b  = ALU_W'(w_r);
      end
      icdf_pkg::S_DIV_PROB: begin
        alu_op = icdf_pkg::ALU_SUB;
        alu_a  = {1'b0, rem_r, 1'b0};
        alu_b  = ALU_W'(total_r);
      end
      default: begin
        alu_op = icdf_pkg::ALU_ADD;
      end
    endcase
  end

  // table read address
  always_comb begin
    unique case (state_r)
      icdf_pkg::S_SEARCH_RD: tbl_rd_addr = mid_c;
      icdf_pkg::S_LO_RD:     tbl_rd_addr = lo_r - IDX_W'(1);
      default:               tbl_rd_addr = lo_r;
    endcase
  end

  assign tbl_wr_en = accept && (in_op == icdf_pkg::OP_APPEND) && !table_full;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      icdf_pkg::S_IDLE: begin
        if (accept && (in_op == icdf_pkg::OP_SAMPLE) && (count_r != '0) &&
            (total_r != '0)) begin
          state_nxt = icdf_pkg::S_MUL;
        end
      end
      icdf_pkg::S_MUL: begin
        if (step_last) begin
          state_nxt = icdf_pkg::S_SEARCH_RD;
        end
      end
      icdf_pkg::S_SEARCH_RD: begin
        state_nxt = (lo_r == hi_r) ? icdf_pkg::S_UP_RD : icdf_pkg::S_SEARCH_CMP;
      end
      icdf_pkg::S_SEARCH_CMP: state_nxt = icdf_pkg::S_SEARCH_RD;
      icdf_pkg::S_UP_RD:      state_nxt = icdf_pkg::S_LO_RD;
      icdf_pkg::S_LO_RD:      state_nxt = icdf_pkg::S_WIDTH;
      icdf_pkg::S_WIDTH:      state_nxt = icdf_pkg::S_OFFSET;
      icdf_pkg::S_OFFSET:     state_nxt = icdf_pkg::S_DIV_FRAC;
      icdf_pkg::S_DIV_FRAC: begin
        if (step_last) begin
          state_nxt = (w_r == total_r) ? icdf_pkg::S_IDLE : icdf_pkg::S_DIV_PROB;
        end
      end
      icdf_pkg::S_DIV_PROB: begin
        if (step_last) begin
          state_nxt = icdf_pkg::S_IDLE;
        end
      end
      default: state_nxt = icdf_pkg::S_IDLE;
    endcase
  end

  // datapath and result next values
  always_comb begin
    count_nxt     = count_r;
    total_nxt     = total_r;
    out_valid_nxt = 1'b0;
    acc_nxt       = acc_r;
    sh_nxt        = sh_r;
    rem_nxt       = rem_r;
    w_nxt         = w_r;
    low_nxt       = low_r;
    up_nxt        = up_r;
    frac_nxt      = frac_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    step_nxt      = step_r;
    bin_nxt       = bin_r;
    bfrac_nxt     = bfrac_r;
    prob_nxt      = prob_r;
    status_nxt    = status_r;
    unique case (state_r)
      // commands answered from idle; a real sample only loads the multiplier here
      icdf_pkg::S_IDLE: begin
        if (accept) begin
          bin_nxt   = '0;
          bfrac_nxt = '0;
          prob_nxt  = '0;
          acc_nxt   = '0;
          sh_nxt    = u_eff;
          step_nxt  = STEP_W'(FRACTION_BITS - 1);
          case (in_op)
            icdf_pkg::OP_CLEAR: begin
              count_nxt     = '0;
              total_nxt     = '0;
              status_nxt    = icdf_pkg::STATUS_OK;
              out_valid_nxt = 1'b1;
            end
            icdf_pkg::OP_APPEND: begin
              out_valid_nxt = 1'b1;
              if (table_full) begin
                status_nxt = icdf_pkg::STATUS_FULL;
              end else begin
                total_nxt  = alu_res[SUM_W-1:0];
                count_nxt  = count_r + CNT_W'(1);
                status_nxt = icdf_pkg::STATUS_OK;
              end
            end
            icdf_pkg::OP_SAMPLE: begin
              status_nxt = icdf_pkg::STATUS_OK;
              if ((count_r == '0) || (total_r == '0)) begin
                status_nxt    = icdf_pkg::STATUS_EMPTY;
                out_valid_nxt = 1'b1;
              end
            end
            default: begin
              status_nxt    = icdf_pkg::STATUS_OK;
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      // shift-add multiply, LSB first; high half ends up as the target
      icdf_pkg::S_MUL: begin
        acc_nxt  = alu_res[SUM_W:1];
        sh_nxt   = {alu_res[0], sh_r[FRACTION_BITS-1:1]};
        step_nxt = step_r - STEP_W'(1);
        if (step_last) begin
          lo_nxt = '0;
          hi_nxt = last_entry[IDX_W-1:0];
        end
      end
      icdf_pkg::S_SEARCH_RD: begin
        mid_nxt = mid_c;
      end
      // probe is above the target when target - probe borrows
      icdf_pkg::S_SEARCH_CMP: begin
        if (borrow) begin
          hi_nxt = mid_r;
        end else begin
          lo_nxt = mid_r + IDX_W'(1);
        end
      end
      icdf_pkg::S_LO_RD: begin
        up_nxt = tbl_rd_data;
      end
      icdf_pkg::S_WIDTH: begin
        w_nxt   = alu_res[SUM_W-1:0];
        low_nxt = lower_c;
      end
      icdf_pkg::S_OFFSET: begin
        rem_nxt  = alu_res[SUM_W-1:0];
        sh_nxt   = '0;
        step_nxt = STEP_W'(FRACTION_BITS - 1);
      end
      // restoring division for the offset inside the bin
      icdf_pkg::S_DIV_FRAC: begin
        rem_nxt  = div_rem;
        sh_nxt   = quot_nxt;
        step_nxt = step_r - STEP_W'(1);
        if (step_last) begin
          frac_nxt = quot_nxt;
          rem_nxt  = w_r;
          sh_nxt   = '0;
          step_nxt = STEP_W'(FRACTION_BITS - 1);
          if (w_r == total_r) begin
            // bin holds all the weight: probability saturates
            bin_nxt       = lo_ext[7:0];
            bfrac_nxt     = quot_ext[15:0];
            prob_nxt      = 16'(32'((1 << FRACTION_BITS) - 1));
            status_nxt    = icdf_pkg::STATUS_OK;
            out_valid_nxt = 1'b1;
          end
        end
      end
      // restoring division for the bin probability
      icdf_pkg::S_DIV_PROB: begin
        rem_nxt  = div_rem;
        sh_nxt   = quot_nxt;
        step_nxt = step_r - STEP_W'(1);
        if (step_last) begin
          bin_nxt       = lo_ext[7:0];
          bfrac_nxt     = frac_ext[15:0];
          prob_nxt      = quot_ext[15:0];
          status_nxt    = icdf_pkg::STATUS_OK;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= icdf_pkg::S_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    sh_r     <= sh_nxt;
    rem_r    <= rem_nxt;
    w_r      <= w_nxt;
    low_r    <= low_nxt;
    up_r     <= up_nxt;
    frac_r   <= frac_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
    step_r   <= step_nxt;
    bin_r    <= bin_nxt;
    bfrac_r  <= bfrac_nxt;
    prob_r   <= prob_nxt;
    status_r <= status_nxt;
  end

  icdf_alu #(
    .W (ALU_W)
  ) u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  icdf_table #(
    .DEPTH  (TABLE_DEPTH),
    .DATA_W (SUM_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data (alu_res[SUM_W-1:0]),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data)
  );

  assign busy             = (state_r != icdf_pkg::S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_bin_index    = bin_r;
  assign out_bin_fraction = bfrac_r;
  assign out_probability  = prob_r;
  assign out_status       = status_r;

  // every accepted command either strobes a result or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("accepted command neither answered nor in progress");

  // a result beat is only ever shown with the sequencer back at rest
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobed while sequencer busy");

  // fill count never runs past the table
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // an empty-table sample reports nothing but the status
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == icdf_pkg::STATUS_EMPTY)) |->
      ((out_bin_index == '0) && (out_bin_fraction == '0) &&
       (out_probability == '0)))
    else $error("empty status with non-zero result fields");

endmodule

/* sim/inverse_cdf_table_sampler_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// inverse_cdf_table_sampler_tb - self-checking bench for the table sampler
// Drives clear, append, draw and unused commands through the start/busy handshake.
// A behavioural copy of the prefix-sum table predicts the untyped result beats.
// A short directed table covers the corner cases. Random command sequences
// follow: table fills up to overflow, and draws with random and extreme
// uniforms. Idle gaps are inserted at random on the command side.
// ----------------------------------------------------------------------------
module inverse_cdf_table_sampler_tb;

  localparam int unsigned TABLE_DEPTH  = 256;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int unsigned RANDOM_BEATS = 1700;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [7:0]  bin_index;
    logic [15:0] bin_fraction;
    logic [15:0] probability;
    logic [1:0]  status;
  } outcome_t;

  typedef struct {
    logic [1:0]  op;
    logic [15:0] weight;
    logic [15:0] uniform;
    bit          typed;
    outcome_t    outcome;
  } stim_row_t;

  // DUT ports
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        start      = 1'b0;
  logic        busy;
  logic [1:0]  in_op      = icdf_pkg::OP_CLEAR;
  logic [15:0] in_weight  = '0;
  logic [15:0] in_uniform = '0;
  logic        out_valid;
  logic [7:0]  out_bin_index;
  logic [15:0] out_bin_fraction;
  logic [15:0] out_probability;
  logic [1:0]  out_status;

  // Predicted table state
  logic [23:0] cdf_upper [TABLE_DEPTH];
  int unsigned bin_count  = 0;
  logic [23:0] weight_sum = '0;

  outcome_t    pending_outcomes [$];
  stim_row_t   directed_rows [$];

  int unsigned errors         = 0;
  int unsigned beats_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned draws_ok       = 0;
  int unsigned draws_empty    = 0;
  int unsigned appends_full   = 0;
  int unsigned cycle_count    = 0;
  bit          no_idle        = 1'b0;

  inverse_cdf_table_sampler dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_weight        (in_weight),
    .in_uniform       (in_uniform),
    .out_valid        (out_valid),
    .out_bin_index    (out_bin_index),
    .out_bin_fraction (out_bin_fraction),
    .out_probability  (out_probability),
    .out_status       (out_status)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
               cycle_count, pending_outcomes.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Behavioural table: updates state and returns the result of one command
  function automatic outcome_t predict_outcome(input logic [1:0] op,
                                               input logic [15:0] weight,
                                               input logic [15:0] uniform);
    outcome_t    res;
    logic [39:0] target, lower, width, frac, prob;
    int unsigned lo, hi, mid;
    res = '0;
    case (op)
      icdf_pkg::OP_CLEAR: begin
        bin_count  = 0;
        weight_sum = '0;
      end
      icdf_pkg::OP_APPEND: begin
        if (bin_count >= TABLE_DEPTH) begin
          res.status = icdf_pkg::STATUS_FULL;
        end else begin
          weight_sum           = weight_sum + 24'(weight);
          cdf_upper[bin_count] = weight_sum;
          bin_count++;
        end
      end
      icdf_pkg::OP_SAMPLE: begin
        if (bin_count == 0 || weight_sum == '0) begin
          res.status = icdf_pkg::STATUS_EMPTY;
        end else begin
          target = (40'(uniform) * 40'(weight_sum)) >> 16;
          // first bin whose upper bound exceeds the target
          lo = 0;
          hi = bin_count - 1;
          while (lo != hi) begin
            mid = (lo + hi) >> 1;
            if (40'(cdf_upper[mid]) > target) hi = mid;
            else lo = mid + 1;
          end
          lower = (lo == 0) ? 40'd0 : 40'(cdf_upper[lo - 1]);
          width = 40'(cdf_upper[lo]) - lower;
          frac  = ((target - lower) << 16) / width;
          prob  = (width << 16) / 40'(weight_sum);
          res.bin_index    = 8'(lo);
          res.bin_fraction = (frac > 40'hFFFF) ? 16'hFFFF : frac[15:0];
          res.probability  = (prob > 40'hFFFF) ? 16'hFFFF : prob[15:0];
          res.status       = icdf_pkg::STATUS_OK;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // One command beat: optional idle gap, then hold start until taken
  task automatic send_beat(input logic [1:0] op, input logic [15:0] weight,
                           input logic [15:0] uniform, input bit typed,
                           input outcome_t typed_res);
    int unsigned gap;
    outcome_t    want;
    gap = 0;
    if (!no_idle && $urandom_range(99) < 31)
      gap = ($urandom_range(9) == 0) ? $urandom_range(1, 70) : $urandom_range(1, 3);
    @(negedge clk);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start      <= 1'b1;
    in_op      <= op;
    in_weight  <= weight;
    in_uniform <= uniform;
    do @(posedge clk); while (busy);
    want = predict_outcome(op, weight, uniform);
    if (typed) want = typed_res;
    pending_outcomes.insert(pending_outcomes.size(), want);
    beats_sent++;
    if (op == icdf_pkg::OP_SAMPLE && want.status == icdf_pkg::STATUS_OK) draws_ok++;
    if (want.status == icdf_pkg::STATUS_EMPTY) draws_empty++;
    if (want.status == icdf_pkg::STATUS_FULL) appends_full++;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  // Result beats are compared with the oldest prediction
  always @(posedge clk) begin : result_check
    outcome_t want;
    if (rst_n && out_valid) begin
      if (pending_outcomes.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, expected none, got %0h/%0h/%0h/%0h",
                 $time, out_bin_index, out_bin_fraction, out_probability, out_status);
      end else begin
        want = pending_outcomes.pop_front();
        results_seen++;
        check_field("bin_index", 32'(want.bin_index), 32'(out_bin_index));
        check_field("bin_fraction", 32'(want.bin_fraction), 32'(out_bin_fraction));
        check_field("probability", 32'(want.probability), 32'(out_probability));
        check_field("status", 32'(want.status), 32'(out_status));
      end
    end
  end

  task automatic add_row(input logic [1:0] op, input logic [15:0] weight,
                         input logic [15:0] uniform, input bit typed,
                         input logic [7:0] bin, input logic [15:0] frac,
                         input logic [15:0] prob, input logic [1:0] st);
    stim_row_t r;
    r.op      = op;
    r.weight  = weight;
    r.uniform = uniform;
    r.typed   = typed;
    r.outcome = '{bin, frac, prob, st};
    directed_rows.insert(directed_rows.size(), r);
  endtask

  initial begin : stimulus
    int unsigned scenario, n_app, n_draw;
    logic [15:0] w, u;

    // Directed corner cases; typed rows carry their result
    add_row(icdf_pkg::OP_SAMPLE, 16'h0000, 16'h1234, 1, 0, 0, 0,
            icdf_pkg::STATUS_EMPTY);                                  // empty after reset
    add_row(icdf_pkg::OP_APPEND, 16'h0000, 16'hFFFF, 1, 0, 0, 0,
            icdf_pkg::STATUS_OK);                                     // zero-weight bin
    add_row(icdf_pkg::OP_SAMPLE, 16'hFFFF, 16'hFFFF, 1, 0, 0, 0,
            icdf_pkg::STATUS_EMPTY);                                  // zero total
    add_row(icdf_pkg::OP_APPEND, 16'hFFFF, 16'h0000, 1, 0, 0, 0, icdf_pkg::STATUS_OK);
    add_row(icdf_pkg::OP_SAMPLE, 16'h0000, 16'h0000, 1, 1, 0, 16'hFFFF,
            icdf_pkg::STATUS_OK);                                     // skips empty bin
    add_row(icdf_pkg::OP_SAMPLE, 16'h0000, 16'hFFFF, 0, 0, 0, 0, icdf_pkg::STATUS_OK);
    add_row(OP_UNUSED, 16'hFFFF, 16'hFFFF, 1, 0, 0, 0, icdf_pkg::STATUS_OK);  // unused code
    add_row(icdf_pkg::OP_APPEND, 16'h0001, 16'h0000, 1, 0, 0, 0, icdf_pkg::STATUS_OK);
    add_row(icdf_pkg::OP_APPEND, 16'h0000, 16'h0000, 1, 0, 0, 0, icdf_pkg::STATUS_OK);
    add_row(icdf_pkg::OP_APPEND, 16'h8000, 16'h0000, 1, 0, 0, 0, icdf_pkg::STATUS_OK);
    add_row(icdf_pkg::OP_SAMPLE, 16'h0000, 16'h0000, 0, 0, 0, 0, icdf_pkg::STATUS_OK);
    add_row(icdf_pkg::OP_SAMPLE, 16'h0000, 16'hFFFF, 0, 0, 0, 0, icdf_pkg::STATUS_OK);
    add_row(icdf_pkg::OP_SAMPLE, 16'h0000, 16'h8000, 0, 0, 0, 0, icdf_pkg::STATUS_OK);
    add_row(icdf_pkg::OP_SAMPLE, 16'hFFFF, 16'h5555, 0, 0, 0, 0, icdf_pkg::STATUS_OK);
    add_row(icdf_pkg::OP_SAMPLE, 16'h0000, 16'hAAAA, 0, 0, 0, 0, icdf_pkg::STATUS_OK);
    add_row(icdf_pkg::OP_CLEAR,  16'hFFFF, 16'hFFFF, 1, 0, 0, 0, icdf_pkg::STATUS_OK);
    add_row(icdf_pkg::OP_SAMPLE, 16'h0000, 16'h1234, 1, 0, 0, 0,
            icdf_pkg::STATUS_EMPTY);                                  // empty after clear
    add_row(icdf_pkg::OP_APPEND, 16'h0001, 16'h0000, 1, 0, 0, 0, icdf_pkg::STATUS_OK);
    add_row(icdf_pkg::OP_SAMPLE, 16'h0000, 16'hFFFF, 1, 0, 0, 16'hFFFF,
            icdf_pkg::STATUS_OK);                                     // all weight
    add_row(icdf_pkg::OP_APPEND, 16'h0001, 16'h0000, 1, 0, 0, 0, icdf_pkg::STATUS_OK);
    add_row(icdf_pkg::OP_SAMPLE, 16'h0000, 16'h8000, 1, 1, 0, 16'h8000, icdf_pkg::STATUS_OK);
    add_row(icdf_pkg::OP_SAMPLE, 16'h0000, 16'h7FFF, 1, 0, 0, 16'h8000, icdf_pkg::STATUS_OK);
    add_row(icdf_pkg::OP_APPEND, 16'hFFFF, 16'h0000, 1, 0, 0, 0, icdf_pkg::STATUS_OK);
    add_row(icdf_pkg::OP_SAMPLE, 16'h0000, 16'hC000, 0, 0, 0, 0, icdf_pkg::STATUS_OK);

    // Reset: held low from time zero, released on a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_beat(directed_rows[i].op, directed_rows[i].weight, directed_rows[i].uniform,
                directed_rows[i].typed, directed_rows[i].outcome);

    // Random command sequences: fill the table, then draw from it
    scenario = 0;
    while (beats_sent < directed_rows.size() + RANDOM_BEATS) begin
      no_idle = (beats_sent >= 700 && beats_sent < 1000);
      if (scenario != 0 && $urandom_range(99) < 15) begin
        // noise: any code, any field contents
        repeat ($urandom_range(1, 6))
          send_beat(2'($urandom_range(3)), 16'($urandom), 16'($urandom), 0, '0);
      end else begin
        if (scenario == 0) n_app = TABLE_DEPTH + 2;
        else if ($urandom_range(99) < 70) n_app = $urandom_range(1, 12);
        else if ($urandom_range(99) < 67) n_app = $urandom_range(13, 64);
        else n_app = $urandom_range(250, 260);
        n_draw = $urandom_range(1, 12);
        if (scenario == 0 || $urandom_range(99) < 80)
          send_beat(icdf_pkg::OP_CLEAR, 16'($urandom), 16'($urandom), 0, '0);
        repeat (n_app) begin
          case ($urandom_range(7))
            0: w = 16'h0000;
            1: w = 16'hFFFF;
            2, 3: w = 16'($urandom_range(1, 15));
            default: w = 16'($urandom);
          endcase
          send_beat(icdf_pkg::OP_APPEND, w, 16'($urandom), 0, '0);
        end
        repeat (n_draw) begin
          case ($urandom_range(9))
            0: u = 16'h0000;
            1: u = 16'hFFFF;
            default: u = 16'($urandom);
          endcase
          send_beat(icdf_pkg::OP_SAMPLE, 16'($urandom), u, 0, '0);
        end
      end
      scenario++;
    end

    // Drain outstanding results, then watch for stray beats
    @(negedge clk);
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d command beats: %0d draws, %0d draws on empty tables, %0d full appends",
             beats_sent, draws_ok, draws_empty, appends_full);
    $display("Checked %0d result beats, %0d mismatches", results_seen, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/icdf_pkg.sv
src/icdf_alu.sv
src/icdf_table.sv
src/inverse_cdf_table_sampler.sv
sim/inverse_cdf_table_sampler_tb.sv
